// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rbr_pkg.sv -----
// ---------------------------------------------------------------------------
// rbr_pkg
// Shared types, codes and helpers of the reorder buffer ring.
// ---------------------------------------------------------------------------
package rbr_pkg;

  localparam int DEPTH_DEFAULT = 16;

  // Entry field widths
  localparam int INST_W  = 16;
  localparam int DEST_W  = 5;
  localparam int KIND_W  = 3;
  localparam int CLASS_W = 2;
  localparam int VALUE_W = 32;
  localparam int CYCLE_W = 32;
  localparam int LAG_W   = 4;
  localparam int IDX_W   = 4;
  localparam int META_W  = INST_W + DEST_W + KIND_W;
  localparam int RES_W   = VALUE_W + CYCLE_W;

  localparam logic [LAG_W-1:0] LAG_RESET = 4'd5;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_WB     = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  localparam logic [KIND_W-1:0] KIND_STORE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LAST_FP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LAST_INT   = 3'd5;

  localparam logic [CLASS_W-1:0] CLASS_FP   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_INT  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction, launch the RAM read
    logic execute;  // apply the operation and load the result registers
  } ctl_t;

  function automatic logic [CLASS_W-1:0] kind_class(input logic [KIND_W-1:0] kind);
    logic [CLASS_W-1:0] cls;
    if (kind <= KIND_LAST_FP) begin
      cls = CLASS_FP;
    end else if (kind <= KIND_LAST_INT) begin
      cls = CLASS_INT;
    end else begin
      cls = CLASS_NONE;
    end
    return cls;
  endfunction

endpackage

// ----- design/rbr_ram.sv -----
// ---------------------------------------------------------------------------
// rbr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rbr_ctrl.sv -----
// ---------------------------------------------------------------------------
// rbr_ctrl
// Two-state sequencer: accept a transaction, then execute it.
// ---------------------------------------------------------------------------
module rbr_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  output rbr_pkg::ctl_t ctl_o,
  output logic         result_strobe_o
);

  rbr_pkg::state_e state_q, state_d;
  rbr_pkg::ctl_t   ctl;
  logic            strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbr_pkg::ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= ctl.execute;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    case (state_q)
      rbr_pkg::ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_d     = rbr_pkg::ST_EXEC;
        end
      end
      rbr_pkg::ST_EXEC: begin
        ctl.execute = 1'b1;
        state_d     = rbr_pkg::ST_IDLE;
      end
      default: begin
        state_d = rbr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_q != rbr_pkg::ST_IDLE);
  assign ctl_o           = ctl;
  assign result_strobe_o = strobe_q;

endmodule

// ----- design/rbr_datapath.sv -----
// ---------------------------------------------------------------------------
// rbr_datapath
// Entry storage, ring pointers, retire check and result registers.
// ---------------------------------------------------------------------------
module rbr_datapath #(
  parameter int DEPTH = rbr_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rbr_pkg::ctl_t                 ctl_i,
  input  logic                          cfg_valid_i,
  input  logic [rbr_pkg::LAG_W-1:0]     cfg_data_i,
  input  logic [1:0]                    action_i,
  input  logic [rbr_pkg::INST_W-1:0]    inst_num_i,
  input  logic [rbr_pkg::KIND_W-1:0]    inst_kind_i,
  input  logic [rbr_pkg::DEST_W-1:0]    dest_reg_i,
  input  logic [rbr_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [rbr_pkg::VALUE_W-1:0]   value_bits_i,
  input  logic [rbr_pkg::CYCLE_W-1:0]   cycle_i,
  input  logic [15:0]                   store_address_i,
  input  logic [31:0]                   store_data_in_i,
  output logic                          commit_valid_o,
  output logic [rbr_pkg::IDX_W-1:0]     commit_index_o,
  output logic                          mem_write_o,
  output logic [15:0]                   mem_address_o,
  output logic [31:0]                   mem_data_o,
  output logic [rbr_pkg::VALUE_W-1:0]   read_value_o,
  output logic                          read_finished_o,
  output logic [rbr_pkg::INST_W-1:0]    read_inst_num_o,
  output logic [rbr_pkg::CLASS_W-1:0]   read_class_o,
  output logic [rbr_pkg::DEST_W-1:0]    read_dest_o,
  output logic [rbr_pkg::IDX_W-1:0]     next_alloc_index_o,
  output logic                          has_free_entry_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = (AW > rbr_pkg::IDX_W) ? AW : rbr_pkg::IDX_W;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Config register
  logic [rbr_pkg::LAG_W-1:0] lag_q;

  // Ring state
  logic [DEPTH-1:0] done_q, done_d;
  logic [DEPTH-1:0] retired_q, retired_d;
  logic [CW-1:0]    ret_cnt_q, ret_cnt_d;
  logic [AW-1:0]    alloc_q, alloc_d;
  logic [AW-1:0]    head_q, head_d;
  logic             filled_q, filled_d;

  // Captured transaction
  rbr_pkg::action_e            act_q;
  logic [rbr_pkg::INST_W-1:0]  inst_q;
  logic [rbr_pkg::KIND_W-1:0]  kind_q;
  logic [rbr_pkg::DEST_W-1:0]  dest_q;
  logic [AW-1:0]               addr_q;
  logic                        idx_ok_q;
  logic [rbr_pkg::VALUE_W-1:0] value_q;
  logic [rbr_pkg::CYCLE_W-1:0] cycle_q;
  logic [15:0]                 saddr_q;
  logic [31:0]                 sdata_q;

  // Index range check against DEPTH
  logic [XW-1:0] idx_x;
  logic          idx_ok;
  logic [AW-1:0] idx_addr;

  assign idx_x    = XW'(entry_index_i);
  assign idx_ok   = ({1'b0, idx_x} < (XW + 1)'(DEPTH));
  assign idx_addr = idx_x[AW-1:0];

  // Entry RAMs
  logic [AW-1:0]              raddr;
  logic                       meta_we;
  logic [rbr_pkg::META_W-1:0] meta_wdata, meta_rdata;
  logic                       res_we;
  logic [AW-1:0]              res_waddr;
  logic [rbr_pkg::RES_W-1:0]  res_wdata, res_rdata;

  assign raddr = (action_i == rbr_pkg::ACT_COMMIT) ? head_q : idx_addr;

  rbr_ram #(.WIDTH(rbr_pkg::META_W), .DEPTH(DEPTH)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (alloc_q),
    .wdata_i (meta_wdata),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  rbr_ram #(.WIDTH(rbr_pkg::RES_W), .DEPTH(DEPTH)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (raddr),
    .rdata_o (res_rdata)
  );

  // Unpack read data
  logic [rbr_pkg::INST_W-1:0]  rd_inst;
  logic [rbr_pkg::DEST_W-1:0]  rd_dest;
  logic [rbr_pkg::KIND_W-1:0]  rd_kind;
  logic [rbr_pkg::VALUE_W-1:0] rd_value;
  logic [rbr_pkg::CYCLE_W-1:0] rd_finish;

  assign {rd_inst, rd_dest, rd_kind} = meta_rdata;
  assign {rd_value, rd_finish}       = res_rdata;

  // Retire check for the head entry
  logic                        alloc_en, wb_en, commit_en, read_en;
  logic                        is_store, head_done, go;
  logic [rbr_pkg::CYCLE_W-1:0] store_due;

  assign alloc_en  = ctl_i.execute && (act_q == rbr_pkg::ACT_ALLOC);
  assign wb_en     = ctl_i.execute && (act_q == rbr_pkg::ACT_WB) && idx_ok_q;
  assign commit_en = ctl_i.execute && (act_q == rbr_pkg::ACT_COMMIT);
  assign read_en   = ctl_i.execute && (act_q == rbr_pkg::ACT_READ) && idx_ok_q;

  assign is_store  = (rd_kind == rbr_pkg::KIND_STORE);
  assign head_done = done_q[head_q];
  assign store_due = cycle_q - rbr_pkg::CYCLE_W'(lag_q);
  assign go = is_store ? (head_done && (rd_finish == store_due))
                       : (head_done && (cycle_q > rd_finish));

  // RAM writes
  assign meta_we    = alloc_en;
  assign meta_wdata = {inst_q, dest_q, kind_q};
  assign res_we     = alloc_en || wb_en;
  assign res_waddr  = alloc_en ? alloc_q : addr_q;
  assign res_wdata  = alloc_en ? '0 : {value_q, cycle_q};

  // Next ring state
  always_comb begin
    done_d    = done_q;
    retired_d = retired_q;
    ret_cnt_d = ret_cnt_q;
    alloc_d   = alloc_q;
    head_d    = head_q;
    filled_d  = filled_q;
    if (alloc_en) begin
      done_d[alloc_q]    = 1'b0;
      retired_d[alloc_q] = 1'b0;
      if (retired_q[alloc_q]) begin
        ret_cnt_d = ret_cnt_q - CW'(1);
      end
      if (alloc_q == LAST) begin
        alloc_d  = '0;
        filled_d = 1'b1;
      end else begin
        alloc_d = alloc_q + AW'(1);
      end
    end
    if (wb_en) begin
      done_d[addr_q] = 1'b1;
    end
    if (commit_en && go) begin
      retired_d[head_q] = 1'b1;
      if (!retired_q[head_q]) begin
        ret_cnt_d = ret_cnt_q + CW'(1);
      end
      head_d = (head_q == LAST) ? '0 : head_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q     <= rbr_pkg::LAG_RESET;
      done_q    <= '0;
      retired_q <= '0;
      ret_cnt_q <= '0;
      alloc_q   <= '0;
      head_q    <= '0;
      filled_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        lag_q <= cfg_data_i;
      end
      done_q    <= done_d;
      retired_q <= retired_d;
      ret_cnt_q <= ret_cnt_d;
      alloc_q   <= alloc_d;
      head_q    <= head_d;
      filled_q  <= filled_d;
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      act_q    <= rbr_pkg::action_e'(action_i);
      inst_q   <= inst_num_i;
      kind_q   <= inst_kind_i;
      dest_q   <= dest_reg_i;
      addr_q   <= idx_addr;
      idx_ok_q <= idx_ok;
      value_q  <= value_bits_i;
      cycle_q  <= cycle_i;
      saddr_q  <= store_address_i;
      sdata_q  <= store_data_in_i;
    end
  end

  // Result registers
  logic [XW-1:0] head_x, alloc_x;
  logic          retire, st_write;

  assign head_x   = XW'(head_q);
  assign alloc_x  = XW'(alloc_d);
  assign retire   = commit_en && go;
  assign st_write = retire && is_store;

  always_ff @(posedge clk_i) begin
    if (ctl_i.execute) begin
      commit_valid_o     <= retire;
      commit_index_o     <= retire ? head_x[rbr_pkg::IDX_W-1:0] : '0;
      mem_write_o        <= st_write;
      mem_address_o      <= st_write ? saddr_q : '0;
      mem_data_o         <= st_write ? sdata_q : '0;
      read_value_o       <= read_en ? rd_value : '0;
      read_finished_o    <= read_en ? done_q[addr_q] : 1'b0;
      read_inst_num_o    <= read_en ? rd_inst : '0;
      read_class_o       <= read_en ? rbr_pkg::kind_class(rd_kind) : '0;
      read_dest_o        <= read_en ? rd_dest : '0;
      next_alloc_index_o <= alloc_x[rbr_pkg::IDX_W-1:0];
      has_free_entry_o   <= !filled_d || (ret_cnt_d != '0);
    end
  end

endmodule

// ----- design/reorder_buffer_ring_top.sv -----
// ---------------------------------------------------------------------------
// reorder_buffer_ring_top
// Circular reorder buffer: allocate, writeback, commit head, read entry.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive the operation fields and raise start. The
//   transaction is taken at a clock edge with start high and busy low.
//   busy stays high for one cycle after that edge.
//   Result channel: every transaction yields exactly one result, shown for
//   one cycle with result_strobe_o high. The receiver cannot stall; results
//   must be captured on that strobe. The result registers hold their last
//   values between strobes. The strobe is registered from the execute state.
//   Busy blocks a new transaction until execute ends. The accept cycle
//   launches the registered read of the entry RAMs; the execute cycle runs
//   the retire check, updates the ring and loads the result registers.
//   Config channel: cfg_data_i (store commit lag) is written whenever
//   cfg_valid_i is high; cfg_ready_o is tied high. Write only while idle.
//   Reset: pointers, fill flag, done and retired bits clear, lag goes to 5.
//   Entry contents are undefined until allocated, so no clearing pass runs
//   and the block takes commands right after reset.
// ---------------------------------------------------------------------------
module reorder_buffer_ring_top #(
  parameter int DEPTH = rbr_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [rbr_pkg::INST_W-1:0]  inst_num_i,
  input  logic [rbr_pkg::KIND_W-1:0]  inst_kind_i,
  input  logic [rbr_pkg::DEST_W-1:0]  dest_reg_i,
  input  logic [rbr_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [rbr_pkg::VALUE_W-1:0] value_bits_i,
  input  logic [rbr_pkg::CYCLE_W-1:0] cycle_i,
  input  logic [15:0]                 store_address_i,
  input  logic [31:0]                 store_data_in_i,
  // config channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rbr_pkg::LAG_W-1:0]   cfg_data_i,
  // result channel
  output logic                        result_strobe_o,
  output logic                        commit_valid_o,
  output logic [rbr_pkg::IDX_W-1:0]   commit_index_o,
  output logic                        mem_write_o,
  output logic [15:0]                 mem_address_o,
  output logic [31:0]                 mem_data_o,
  output logic [rbr_pkg::VALUE_W-1:0] read_value_o,
  output logic                        read_finished_o,
  output logic [rbr_pkg::INST_W-1:0]  read_inst_num_o,
  output logic [rbr_pkg::CLASS_W-1:0] read_class_o,
  output logic [rbr_pkg::DEST_W-1:0]  read_dest_o,
  output logic [rbr_pkg::IDX_W-1:0]   next_alloc_index_o,
  output logic                        has_free_entry_o
);

  rbr_pkg::ctl_t ctl;

  // Config register is always writable
  assign cfg_ready_o = 1'b1;

  // Sequencer: accept, then execute
  rbr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .ctl_o           (ctl),
    .result_strobe_o (result_strobe_o)
  );

  // Entry storage, pointers and result registers
  rbr_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .action_i           (action_i),
    .inst_num_i         (inst_num_i),
    .inst_kind_i        (inst_kind_i),
    .dest_reg_i         (dest_reg_i),
    .entry_index_i      (entry_index_i),
    .value_bits_i       (value_bits_i),
    .cycle_i            (cycle_i),
    .store_address_i    (store_address_i),
    .store_data_in_i    (store_data_in_i),
    .commit_valid_o     (commit_valid_o),
    .commit_index_o     (commit_index_o),
    .mem_write_o        (mem_write_o),
    .mem_address_o      (mem_address_o),
    .mem_data_o         (mem_data_o),
    .read_value_o       (read_value_o),
    .read_finished_o    (read_finished_o),
    .read_inst_num_o    (read_inst_num_o),
    .read_class_o       (read_class_o),
    .read_dest_o        (read_dest_o),
    .next_alloc_index_o (next_alloc_index_o),
    .has_free_entry_o   (has_free_entry_o)
  );

endmodule

// ----- design/rbr_checker.sv -----
// ---------------------------------------------------------------------------
// rbr_checker
// Port-level timing checks of the reorder buffer ring, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_strobe_o,
  input logic        commit_valid_o,
  input logic        mem_write_o
);

  `RBR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy, "not busy after accept")

  `RBR_ASSERT_IMP(a_result_latency, clk_i, rst_ni, start && !busy, ##2 result_strobe_o, "result missing two cycles after accept")

  `RBR_ASSERT_IMP(a_idle_on_result, clk_i, rst_ni, result_strobe_o, !busy, "busy while result shown")

  `RBR_ASSERT_IMP(a_store_commits, clk_i, rst_ni, result_strobe_o && mem_write_o, commit_valid_o, "memory write without commit")

endmodule

bind reorder_buffer_ring_top rbr_checker u_rbr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .commit_valid_o  (commit_valid_o),
  .mem_write_o     (mem_write_o)
);

// ----- bench/rbr_ring_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbr_ring_checker
// Watches the command, config and result channels of the reorder buffer
// ring, keeps its own copy of the ring and checks every result strobe
// against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module rbr_ring_checker #(
  parameter int DEPTH = rbr_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [rbr_pkg::INST_W-1:0]  inst_num_i,
  input  logic [rbr_pkg::KIND_W-1:0]  inst_kind_i,
  input  logic [rbr_pkg::DEST_W-1:0]  dest_reg_i,
  input  logic [rbr_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [rbr_pkg::VALUE_W-1:0] value_bits_i,
  input  logic [rbr_pkg::CYCLE_W-1:0] cycle_i,
  input  logic [15:0]                 store_address_i,
  input  logic [31:0]                 store_data_in_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [rbr_pkg::LAG_W-1:0]   cfg_data_i,
  input  logic                        result_strobe_i,
  input  logic                        commit_valid_i,
  input  logic [rbr_pkg::IDX_W-1:0]   commit_index_i,
  input  logic                        mem_write_i,
  input  logic [15:0]                 mem_address_i,
  input  logic [31:0]                 mem_data_i,
  input  logic [rbr_pkg::VALUE_W-1:0] read_value_i,
  input  logic                        read_finished_i,
  input  logic [rbr_pkg::INST_W-1:0]  read_inst_num_i,
  input  logic [rbr_pkg::CLASS_W-1:0] read_class_i,
  input  logic [rbr_pkg::DEST_W-1:0]  read_dest_i,
  input  logic [rbr_pkg::IDX_W-1:0]   next_alloc_index_i,
  input  logic                        has_free_entry_i,
  output int                          mismatch_cnt_o,
  output int                          due_cnt_o
);
  import rbr_pkg::*;

  typedef struct packed {
    logic                commit_valid;
    logic [IDX_W-1:0]    commit_index;
    logic                mem_write;
    logic [15:0]         mem_address;
    logic [31:0]         mem_data;
    logic [VALUE_W-1:0]  read_value;
    logic                read_finished;
    logic [INST_W-1:0]   read_inst_num;
    logic [CLASS_W-1:0]  read_class;
    logic [DEST_W-1:0]   read_dest;
    logic [IDX_W-1:0]    next_alloc;
    logic                has_free;
  } rob_outcome_t;

  // Shadow ring
  logic [INST_W-1:0]  rob_inst   [DEPTH];
  logic [DEST_W-1:0]  rob_dest   [DEPTH];
  logic [VALUE_W-1:0] rob_value  [DEPTH];
  logic [KIND_W-1:0]  rob_kind   [DEPTH];
  logic [CLASS_W-1:0] rob_cls    [DEPTH];
  logic [CYCLE_W-1:0] rob_finish [DEPTH];
  logic [DEPTH-1:0]   rob_done;
  logic [DEPTH-1:0]   rob_retired;
  logic [IDX_W-1:0]   alloc_ptr;
  logic [IDX_W-1:0]   head_ptr;
  logic               wrapped;
  logic [LAG_W-1:0]   lag;

  rob_outcome_t outcomes_due[$];
  int mismatches = 0;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one transaction to the shadow ring, returns the result it must give.
  function automatic rob_outcome_t advance_ring(
    input action_e            act,
    input logic [INST_W-1:0]  inst,
    input logic [KIND_W-1:0]  kind,
    input logic [DEST_W-1:0]  dest,
    input logic [IDX_W-1:0]   idx,
    input logic [VALUE_W-1:0] value,
    input logic [CYCLE_W-1:0] cyc,
    input logic [15:0]        addr,
    input logic [31:0]        data
  );
    rob_outcome_t o;
    logic         retire;
    logic [CYCLE_W-1:0] due_cycle;
    o      = '0;
    retire = 1'b0;
    case (act)
      ACT_ALLOC: begin
        rob_inst[alloc_ptr]    = inst;
        rob_dest[alloc_ptr]    = dest;
        rob_value[alloc_ptr]   = '0;
        rob_kind[alloc_ptr]    = kind;
        rob_cls[alloc_ptr]     = (kind > KIND_LAST_INT) ? CLASS_NONE :
                                 (kind > KIND_LAST_FP)  ? CLASS_INT  : CLASS_FP;
        rob_finish[alloc_ptr]  = '0;
        rob_done[alloc_ptr]    = 1'b0;
        rob_retired[alloc_ptr] = 1'b0;
        if (alloc_ptr == IDX_W'(DEPTH - 1)) wrapped = 1'b1;
        alloc_ptr = ring_next(alloc_ptr);
      end
      ACT_WB: begin
        rob_value[idx]  = value;
        rob_done[idx]   = 1'b1;
        rob_finish[idx] = cyc;
      end
      ACT_COMMIT: begin
        if (rob_kind[head_ptr] == KIND_STORE) begin
          // store retires only when the commit cycle equals its finish cycle plus lag, mod 2^32
          due_cycle = cyc - {{(CYCLE_W-LAG_W){1'b0}}, lag};
          if (rob_done[head_ptr] && rob_finish[head_ptr] == due_cycle) begin
            retire        = 1'b1;
            o.mem_write   = 1'b1;
            o.mem_address = addr;
            o.mem_data    = data;
          end
        end else if (rob_done[head_ptr] && cyc > rob_finish[head_ptr]) begin
          retire = 1'b1;
        end
        if (retire) begin
          o.commit_valid        = 1'b1;
          o.commit_index        = head_ptr;
          rob_retired[head_ptr] = 1'b1;
          head_ptr              = ring_next(head_ptr);
        end
      end
      default: begin
        o.read_value    = rob_value[idx];
        o.read_finished = rob_done[idx];
        o.read_inst_num = rob_inst[idx];
        o.read_class    = rob_cls[idx];
        o.read_dest     = rob_dest[idx];
      end
    endcase
    o.next_alloc = alloc_ptr;
    o.has_free   = !wrapped || (|rob_retired);
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : b_track
    rob_outcome_t want;
    if (!rst_ni) begin
      rob_done    = '0;
      rob_retired = '0;
      alloc_ptr   = '0;
      head_ptr    = '0;
      wrapped     = 1'b0;
      lag         = LAG_RESET;
      outcomes_due.delete();
    end else begin
      // compare before pushing: a strobe never belongs to this edge's transaction
      if (result_strobe_i) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: result expected none actual strobe", $time);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("commit_valid", 32'(want.commit_valid), 32'(commit_valid_i));
          check_field("commit_index", 32'(want.commit_index), 32'(commit_index_i));
          check_field("mem_write", 32'(want.mem_write), 32'(mem_write_i));
          check_field("mem_address", 32'(want.mem_address), 32'(mem_address_i));
          check_field("mem_data", want.mem_data, mem_data_i);
          check_field("read_value", want.read_value, read_value_i);
          check_field("read_finished", 32'(want.read_finished), 32'(read_finished_i));
          check_field("read_inst_num", 32'(want.read_inst_num), 32'(read_inst_num_i));
          check_field("read_class", 32'(want.read_class), 32'(read_class_i));
          check_field("read_dest", 32'(want.read_dest), 32'(read_dest_i));
          check_field("next_alloc_index", 32'(want.next_alloc), 32'(next_alloc_index_i));
          check_field("has_free_entry", 32'(want.has_free), 32'(has_free_entry_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) lag = cfg_data_i;
      if (start && !busy) begin
        outcomes_due.push_back(advance_ring(action_e'(action_i), inst_num_i, inst_kind_i,
                                            dest_reg_i, entry_index_i, value_bits_i,
                                            cycle_i, store_address_i, store_data_in_i));
      end
    end
    mismatch_cnt_o <= mismatches;
    due_cnt_o      <= outcomes_due.size();
  end

endmodule

// ----- bench/reorder_buffer_ring_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// reorder_buffer_ring_top_tb
// Drives the reorder buffer ring with a directed sequence and then with
// random allocate / writeback / commit / read traffic under several store
// commit lags; a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module reorder_buffer_ring_top_tb;
  import rbr_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // Instruction kind codes beyond the store code the package names
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FADD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FMUL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IADD   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IADDI  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_OTHER0 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_OTHER1 = 3'd7;

  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    action_e            act;
    logic [INST_W-1:0]  inst;
    logic [KIND_W-1:0]  kind;
    logic [DEST_W-1:0]  dest;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic [CYCLE_W-1:0] cyc;
    logic [15:0]        addr;
    logic [31:0]        data;
  } rob_cmd_t;

  // DUT inputs, all known from time zero
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               start           = 1'b0;
  logic [1:0]         action_i        = '0;
  logic [INST_W-1:0]  inst_num_i      = '0;
  logic [KIND_W-1:0]  inst_kind_i     = '0;
  logic [DEST_W-1:0]  dest_reg_i      = '0;
  logic [IDX_W-1:0]   entry_index_i   = '0;
  logic [VALUE_W-1:0] value_bits_i    = '0;
  logic [CYCLE_W-1:0] cycle_i         = '0;
  logic [15:0]        store_address_i = '0;
  logic [31:0]        store_data_in_i = '0;
  logic               cfg_valid_i     = 1'b0;
  logic [LAG_W-1:0]   cfg_data_i      = '0;

  // DUT outputs
  logic               busy;
  logic               cfg_ready_o;
  logic               result_strobe_o;
  logic               commit_valid_o;
  logic [IDX_W-1:0]   commit_index_o;
  logic               mem_write_o;
  logic [15:0]        mem_address_o;
  logic [31:0]        mem_data_o;
  logic [VALUE_W-1:0] read_value_o;
  logic               read_finished_o;
  logic [INST_W-1:0]  read_inst_num_o;
  logic [CLASS_W-1:0] read_class_o;
  logic [DEST_W-1:0]  read_dest_o;
  logic [IDX_W-1:0]   next_alloc_index_o;
  logic               has_free_entry_o;

  int mismatch_cnt;
  int due_cnt;

  // Stimulus bookkeeping: what we put in each entry, used only to aim
  // commit cycles so that stores and other kinds actually retire.
  logic [KIND_W-1:0]  ent_kind   [DEPTH];
  logic [CYCLE_W-1:0] ent_finish [DEPTH];
  int                 alloc_total = 0;
  logic [IDX_W-1:0]   alloc_next  = '0;
  logic [IDX_W-1:0]   head_seen   = '0;
  logic [LAG_W-1:0]   lag_now     = LAG_RESET;
  logic [CYCLE_W-1:0] now_cyc     = '0;
  int                 burst_left  = 0;

  reorder_buffer_ring_top #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .inst_num_i         (inst_num_i),
    .inst_kind_i        (inst_kind_i),
    .dest_reg_i         (dest_reg_i),
    .entry_index_i      (entry_index_i),
    .value_bits_i       (value_bits_i),
    .cycle_i            (cycle_i),
    .store_address_i    (store_address_i),
    .store_data_in_i    (store_data_in_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .result_strobe_o    (result_strobe_o),
    .commit_valid_o     (commit_valid_o),
    .commit_index_o     (commit_index_o),
    .mem_write_o        (mem_write_o),
    .mem_address_o      (mem_address_o),
    .mem_data_o         (mem_data_o),
    .read_value_o       (read_value_o),
    .read_finished_o    (read_finished_o),
    .read_inst_num_o    (read_inst_num_o),
    .read_class_o       (read_class_o),
    .read_dest_o        (read_dest_o),
    .next_alloc_index_o (next_alloc_index_o),
    .has_free_entry_o   (has_free_entry_o)
  );

  rbr_ring_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .inst_num_i         (inst_num_i),
    .inst_kind_i        (inst_kind_i),
    .dest_reg_i         (dest_reg_i),
    .entry_index_i      (entry_index_i),
    .value_bits_i       (value_bits_i),
    .cycle_i            (cycle_i),
    .store_address_i    (store_address_i),
    .store_data_in_i    (store_data_in_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .result_strobe_i    (result_strobe_o),
    .commit_valid_i     (commit_valid_o),
    .commit_index_i     (commit_index_o),
    .mem_write_i        (mem_write_o),
    .mem_address_i      (mem_address_o),
    .mem_data_i         (mem_data_o),
    .read_value_i       (read_value_o),
    .read_finished_i    (read_finished_o),
    .read_inst_num_i    (read_inst_num_o),
    .read_class_i       (read_class_o),
    .read_dest_i        (read_dest_o),
    .next_alloc_index_i (next_alloc_index_o),
    .has_free_entry_i   (has_free_entry_o),
    .mismatch_cnt_o     (mismatch_cnt),
    .due_cnt_o          (due_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop; a healthy run ends well inside this window.
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  // Track where the head went from retire results, so commits can be aimed
  // at the head entry. One transaction stale at full rate, which is fine.
  always @(posedge clk_i) begin
    if (result_strobe_o && commit_valid_o) begin
      head_seen <= (commit_index_o == IDX_W'(DEPTH - 1)) ? '0 : commit_index_o + 1'b1;
    end
  end

  function automatic rob_cmd_t mk(
    input action_e act, input logic [INST_W-1:0] inst, input logic [KIND_W-1:0] kind,
    input logic [DEST_W-1:0] dest, input logic [IDX_W-1:0] idx,
    input logic [VALUE_W-1:0] value, input logic [CYCLE_W-1:0] cyc,
    input logic [15:0] addr, input logic [31:0] data
  );
    rob_cmd_t c;
    c = '{act, inst, kind, dest, idx, value, cyc, addr, data};
    return c;
  endfunction

  // One random transaction, mostly well aimed: writebacks near the head,
  // commits on the exact store cycle or just past a finish time.
  function automatic rob_cmd_t random_cmd();
    rob_cmd_t         c;
    int               pick;
    logic [IDX_W-1:0] h;
    c.act   = ACT_READ;
    c.inst  = INST_W'($urandom_range(0, 16'hFFFF));
    c.kind  = KIND_W'($urandom_range(0, 7));
    c.dest  = DEST_W'($urandom_range(0, 31));
    c.idx   = IDX_W'($urandom_range(0, DEPTH - 1));
    c.value = $urandom;
    c.cyc   = $urandom;
    c.addr  = 16'($urandom_range(0, 16'hFFFF));
    c.data  = $urandom;
    h       = head_seen;
    pick    = $urandom_range(0, 99);
    // never touch an entry before it was allocated: fill the ring first
    if (alloc_total < DEPTH || pick < 22) begin
      c.act = ACT_ALLOC;
      if ($urandom_range(0, 2) == 0) c.kind = KIND_STORE;
    end else if (pick < 50) begin
      c.act = ACT_WB;
      if ($urandom_range(0, 4) != 0) c.idx = h + IDX_W'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0) c.cyc = now_cyc;
    end else if (pick < 85) begin
      c.act = ACT_COMMIT;
      pick  = $urandom_range(0, 99);
      if (ent_kind[h] == KIND_STORE) begin
        if (pick < 75) c.cyc = ent_finish[h] + lag_now;
        else if (pick < 90) c.cyc = ent_finish[h] + lag_now + 1;
      end else begin
        if (pick < 70) c.cyc = ent_finish[h] + 1 + $urandom_range(0, 20);
        else if (pick < 85) c.cyc = ent_finish[h];
      end
    end
    return c;
  endfunction

  // Present one transaction and hold it until taken (start high, busy low).
  // start is left high so back-to-back transactions need no extra edge.
  task automatic issue(input rob_cmd_t c);
    action_i        <= c.act;
    inst_num_i      <= c.inst;
    inst_kind_i     <= c.kind;
    dest_reg_i      <= c.dest;
    entry_index_i   <= c.idx;
    value_bits_i    <= c.value;
    cycle_i         <= c.cyc;
    store_address_i <= c.addr;
    store_data_in_i <= c.data;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c.act == ACT_ALLOC) begin
      ent_kind[alloc_next]   = c.kind;
      ent_finish[alloc_next] = '0;
      alloc_next = (alloc_next == IDX_W'(DEPTH - 1)) ? '0 : alloc_next + 1'b1;
      alloc_total++;
    end else if (c.act == ACT_WB) begin
      ent_finish[c.idx] = c.cyc;
    end
  endtask

  // Sender idling: bursts of random length, random gaps between them.
  // Called right before each random issue, so start gets one assignment per step.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every outstanding transaction has its result.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lag(input logic [LAG_W-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lag_now = v;
  endtask

  initial begin : stimulus
    rob_cmd_t         plan[$];
    logic [LAG_W-1:0] lag_plan [4];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset lag of 5 in force, head starts at entry 0.
    // Every kind gets allocated once, extremes of number and destination.
    plan.push_back(mk(ACT_ALLOC, 16'hFFFF, KIND_STORE, 5'd31, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'h0000, KIND_LOAD, 5'd0, '1, '1, '1, '1, '1));
    plan.push_back(mk(ACT_ALLOC, 16'h1234, KIND_OTHER1, 5'd5, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'h00FF, KIND_IADD, 5'd16, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'hA5A5, KIND_IADDI, 5'd10, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'h5A5A, KIND_FADD, 5'd21, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'h8000, KIND_FMUL, 5'd1, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_ALLOC, 16'h0001, KIND_OTHER0, 5'd30, '0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_READ, '0, '0, '0, 4'd0, '0, '0, '0, '0));
    plan.push_back(mk(ACT_READ, '0, '0, '0, 4'd2, '0, '0, '0, '0));
    // store at head, not yet finished
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd100, '0, '0));
    // store finishes near the top of the cycle range: commit cycle wraps
    plan.push_back(mk(ACT_WB, '0, '0, '0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd2, 16'hFFFF, 32'hFFFF_FFFF));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd3, 16'hFFFF, 32'hFFFF_FFFF));
    // load: same cycle as finish must not retire, one later must
    plan.push_back(mk(ACT_WB, '0, '0, '0, 4'd1, 32'h0000_0000, 32'd10, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd10, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd11, '0, '0));
    plan.push_back(mk(ACT_READ, '0, '0, '0, 4'd1, '0, '0, '0, '0));
    // writeback into an entry not yet allocated: only written, never read
    plan.push_back(mk(ACT_WB, '0, '0, '0, 4'd15, 32'hA5A5_A5A5, 32'd0, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'hFFFF_FFFF, '0, '0));
    plan.push_back(mk(ACT_WB, '0, '0, '0, 4'd2, 32'h5A5A_5A5A, 32'd0, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd0, '0, '0));
    plan.push_back(mk(ACT_COMMIT, '0, '0, '0, '0, '0, 32'd1, '0, '0));
    plan.push_back(mk(ACT_READ, '0, '0, '0, 4'd0, '0, '0, '0, '0));
    foreach (plan[i]) issue(plan[i]);
    drain();

    // Random phases, each under its own lag; lag is only changed once the
    // ring has gone quiet.
    lag_plan = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), LAG_RESET};
    now_cyc  = $urandom;
    foreach (lag_plan[p]) begin
      write_lag(lag_plan[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pace();
        issue(random_cmd());
        now_cyc += $urandom_range(1, 3);
      end
      drain();
    end

    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
